@@ rtl/bsc_pkg.sv @@
// Shared widths and fixed-point constants for the Bhaskara sine/cosine pipeline.
package bsc_pkg;

  // Defaults for the top-level parameters
  localparam int ANGLE_BITS_DEF       = 16;
  localparam int RESULT_FRAC_BITS_DEF = 14;

  // Angle aligned to 16 fractional bits spans [-4, 4): 19 bits signed
  localparam int XAW = 19;
  // Angle after the optional pi/2 offset, and pi minus angle: 20 bits signed
  localparam int XW  = 20;
  // Product x * (pi - x) at 32 fractional bits: |p| < 2^37
  localparam int PW  = 38;
  // Numerator magnitude 16*|p| < 2^41, divider remainder stays below 2^41
  localparam int RW  = 41;
  // Denominator 5*pi^2 - 4*p is positive and below 2^40
  localparam int DW  = 40;

  // Register stages in front of the divider
  localparam int PREP_STAGES = 3;

  // Pi in unsigned Q.16, its truncated half, and 5*pi^2 at 32 fractional bits
  localparam logic [XW-1:0] PI_Q16      = 20'd205887;
  localparam logic [XW-1:0] HALF_PI_Q16 = 20'd102943;
  localparam logic [DW-1:0] FIVE_PI_SQ  = 40'd211947283845;

endpackage

@@ rtl/bsc_prep.sv @@
// Front end: angle alignment, cosine offset, product and numerator/denominator forming.
module bsc_prep import bsc_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  neg_o,
  output logic [RW-1:0]         mag_o,
  output logic [DW-1:0]         den_o
);

  localparam int ANGLE_FRAC = ANGLE_BITS - 3;

  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_rdy, b_rdy, c_rdy;

  logic signed [XAW-1:0]  x_al;
  logic signed [XW-1:0]   x_ext, x_d, m_d;
  logic signed [XW-1:0]   x_q, m_q;
  logic signed [2*XW-1:0] prod;
  logic signed [PW-1:0]   p_d, p_q;
  logic [PW-1:0]          abs_p;
  logic signed [DW-1:0]   p4;
  logic                   neg_d, neg_q;
  logic [RW-1:0]          mag_d, mag_q;
  logic [DW-1:0]          den_d, den_q;

  // Per-stage ready: a stage takes a new item when empty or when it moves on
  assign c_rdy      = !c_valid_q || out_ready_i;
  assign b_rdy      = !b_valid_q || c_rdy;
  assign a_rdy      = !a_valid_q || b_rdy;
  assign in_ready_o = a_rdy;

  // Align the angle to 16 fractional bits, rounding finer angles down
  generate
    if (ANGLE_FRAC <= 16) begin : g_shl
      localparam int SHL = 16 - ANGLE_FRAC;
      assign x_al = XAW'(signed'(angle_i)) <<< SHL;
    end else begin : g_shr
      localparam int SHR = ANGLE_FRAC - 16;
      logic signed [ANGLE_BITS-1:0] sh;
      assign sh   = signed'(angle_i) >>> SHR;
      assign x_al = sh[XAW-1:0];
    end
  endgenerate

  // Stage A: add pi/2 for cosine, form pi - x
  assign x_ext = XW'(x_al);
  assign x_d   = cmd_i ? x_ext + signed'(HALF_PI_Q16) : x_ext;
  assign m_d   = signed'(PI_Q16) - x_d;

  // Stage B: product x * (pi - x)
  assign prod = x_q * m_q;
  assign p_d  = prod[PW-1:0];

  // Stage C: numerator sign and magnitude, denominator
  assign abs_p = p_q[PW-1] ? unsigned'(-p_q) : unsigned'(p_q);
  assign neg_d = p_q[PW-1];
  assign mag_d = {abs_p[PW-2:0], 4'b0000};
  assign p4    = DW'(p_q) <<< 2;
  assign den_d = FIVE_PI_SQ - unsigned'(p4);

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_rdy) a_valid_q <= in_valid_i;
      if (b_rdy) b_valid_q <= a_valid_q;
      if (c_rdy) c_valid_q <= b_valid_q;
    end
  end

  // Advance payload alongside
  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      x_q <= x_d;
      m_q <= m_d;
    end
    if (b_rdy) begin
      p_q <= p_d;
    end
    if (c_rdy) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
      den_q <= den_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign neg_o       = neg_q;
  assign mag_o       = mag_q;
  assign den_o       = den_q;

endmodule

@@ rtl/bsc_div_step.sv @@
// One registered restoring-division step: decides one quotient bit.
module bsc_div_step import bsc_pkg::*; #(
  parameter int QW   = RESULT_FRAC_BITS_DEF + 2,
  parameter int STEP = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          neg_i,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          neg_o,
  output logic [RW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o
);

  logic          valid_q;
  logic          rdy;
  logic [RW-1:0] part, dvs, diff, rem_d;
  logic          take;
  logic [QW-1:0] quo_d;
  logic          neg_q;
  logic [RW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quo_q;

  assign rdy        = !valid_q || out_ready_i;
  assign in_ready_o = rdy;

  // Pick the partial remainder and trial divisor for this bit position:
  // first the twos bit against 2*den, then the ones bit, then fraction bits
  always_comb begin
    if (STEP == 0) begin
      part = rem_i;
      dvs  = {den_i, 1'b0};
    end else if (STEP == 1) begin
      part = rem_i;
      dvs  = {1'b0, den_i};
    end else begin
      part = {rem_i[RW-2:0], 1'b0};
      dvs  = {1'b0, den_i};
    end
  end

  // Subtract when it fits, shift the decision into the quotient
  assign take  = part >= dvs;
  assign diff  = part - dvs;
  assign rem_d = take ? diff : part;
  assign quo_d = {quo_i[QW-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      neg_q <= neg_i;
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign out_valid_o = valid_q;
  assign neg_o       = neg_q;
  assign rem_o       = rem_q;
  assign den_o       = den_q;
  assign quo_o       = quo_q;

endmodule

@@ rtl/bhaskara_sine_cosine.sv @@
// Top level of the pipelined Bhaskara sine/cosine approximation.
//
//  Channel | Signals                            | Item contents
//  --------+------------------------------------+----------------------------------
//  s_axis  | tvalid, tready, tdata, tuser       | angle (signed Q3.13), cmd
//  m_axis  | tvalid, tready, tdata              | value (signed Q3.14)
//
//  Takes one item per cycle while m_axis accepts results; the pipeline holds
//  three front-end stages (align/offset, multiply, numerator/denominator), one
//  divider stage per quotient bit (RESULT_FRAC_BITS + 2), and the output register.
//  Reset clears all valid bits; the datapath holds no state between items.
//  Each stage stalls only when it is full and its successor cannot take its item,
//  so empty stages keep filling while a result waits on m_axis.
module bhaskara_sine_cosine import bsc_pkg::*; #(
  parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF,
  localparam int IDW = ((ANGLE_BITS + 7) / 8) * 8,
  localparam int VW  = RESULT_FRAC_BITS + 3,
  localparam int ODW = ((VW + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [IDW-1:0] s_axis_tdata,  // [ANGLE_BITS-1:0] angle, rest zero
  input  logic [0:0]     s_axis_tuser,  // [0] cmd
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [ODW-1:0] m_axis_tdata   // [VW-1:0] value, rest zero
);

  localparam int QW    = RESULT_FRAC_BITS + 2;
  localparam int NSTEP = QW;

  logic          vld_c [NSTEP+1];
  logic          rdy_c [NSTEP+1];
  logic          neg_c [NSTEP+1];
  logic [RW-1:0] rem_c [NSTEP+1];
  logic [DW-1:0] den_c [NSTEP+1];
  logic [QW-1:0] quo_c [NSTEP+1];

  logic          out_valid_q;
  logic [VW-1:0] value_q;
  logic [VW-1:0] q_ext, value_d;
  logic          out_rdy;

  // Front end
  bsc_prep #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser[0]),
    .angle_i     (s_axis_tdata[ANGLE_BITS-1:0]),
    .out_valid_o (vld_c[0]),
    .out_ready_i (rdy_c[0]),
    .neg_o       (neg_c[0]),
    .mag_o       (rem_c[0]),
    .den_o       (den_c[0])
  );

  assign quo_c[0] = '0;

  // Divider: one quotient bit per stage, integer bits first
  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    bsc_div_step #(
      .QW   (QW),
      .STEP (k)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld_c[k]),
      .in_ready_o  (rdy_c[k]),
      .neg_i       (neg_c[k]),
      .rem_i       (rem_c[k]),
      .den_i       (den_c[k]),
      .quo_i       (quo_c[k]),
      .out_valid_o (vld_c[k+1]),
      .out_ready_i (rdy_c[k+1]),
      .neg_o       (neg_c[k+1]),
      .rem_o       (rem_c[k+1]),
      .den_o       (den_c[k+1]),
      .quo_o       (quo_c[k+1])
    );
  end

  // Output register: apply the sign and hold the item until taken
  assign out_rdy      = !out_valid_q || m_axis_tready;
  assign rdy_c[NSTEP] = out_rdy;
  assign q_ext        = VW'(quo_c[NSTEP]);
  assign value_d      = neg_c[NSTEP] ? -q_ext : q_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= vld_c[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      value_q <= value_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'(value_q);

`ifndef SYNTHESIS
  localparam int DEPTH = PREP_STAGES + NSTEP + 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic signed [VW-1:0] ONE_V = {3'b001, {RESULT_FRAC_BITS{1'b0}}};
  localparam logic signed [VW-1:0] MIN_V = {3'b100, {RESULT_FRAC_BITS{1'b0}}};

  logic [CW-1:0]        inflight_q;
  logic signed [VW-1:0] value_s;

  assign value_s = signed'(value_q);

  // Track items inside the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CW'(s_axis_tvalid && s_axis_tready)
                               - CW'(m_axis_tvalid && m_axis_tready);
    end
  end

  // Result lies in (-4, 1]
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (value_s <= ONE_V) && (value_s > MIN_V))
    else $error("result outside (-4, 1]");

  // Never more items in flight than stages
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CW'(DEPTH))
    else $error("pipeline holds more items than stages");

  // A result is shown only for an accepted item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result without a matching input item");

  // Input backpressure only when every stage is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> inflight_q == CW'(DEPTH))
    else $error("input stalled while the pipeline has a bubble");
`endif

endmodule
